// ===== design/hav_pkg.sv =====
// Shared widths, constants and arctangent table for the haversine distance datapath.
package hav_pkg;

	// CORDIC datapath width: Q2.30 values with headroom for gain growth
	localparam int CW = 34;

	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [30:0]          ONE_Q30  = 31'd1073741824;

	// Angles in 1e-7 degree
	localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
	localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

	// round(pi * 2^62 / 1.8e9), split into two partial-product halves
	localparam logic [63:0] RAD_MUL =
		(64'hC90FDAA22168C234 + 64'd900000000) / 64'd1800000000;
	localparam logic [15:0] RAD_HI = RAD_MUL[32:17];
	localparam logic [16:0] RAD_LO = RAD_MUL[16:0];

	localparam logic [22:0] EARTH_M = 23'd6371000;

	function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
		logic signed [CW-1:0] r;
		case (i)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			10: r = 34'sd1048576;
			default: r = (i <= 30) ? CW'(64'd1 << (30 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/hav_cordic.sv =====
// Pipelined CORDIC, one step per register stage, rotation or vectoring mode.
module hav_cordic #(
	parameter int STEPS  = 32,
	parameter bit VECTOR = 1'b0
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [hav_pkg::CW-1:0] x_in,
	input  logic signed [hav_pkg::CW-1:0] y_in,
	input  logic signed [hav_pkg::CW-1:0] z_in,
	output logic signed [hav_pkg::CW-1:0] x_out,
	output logic signed [hav_pkg::CW-1:0] y_out,
	output logic signed [hav_pkg::CW-1:0] z_out
);
	import hav_pkg::*;

	logic signed [CW-1:0] x_s [STEPS];
	logic signed [CW-1:0] y_s [STEPS];
	logic signed [CW-1:0] z_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic signed [CW-1:0] ATAN_K = atan_q30(k);
		logic signed [CW-1:0] xi, yi, zi;
		logic signed [CW-1:0] dx, dy;
		logic                 up;

		if (k == 0) begin : g_first
			assign xi = x_in;
			assign yi = y_in;
			assign zi = z_in;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
		end

		assign dx = yi >>> k;
		assign dy = xi >>> k;
		// vectoring drives y to zero, rotation drives z to zero
		assign up = VECTOR ? (yi >= 0) : (zi < 0);

		always_ff @(posedge clk) begin
			if (en) begin
				if (up) begin
					x_s[k] <= xi + dx;
					y_s[k] <= yi - dy;
					z_s[k] <= zi + ATAN_K;
				end else begin
					x_s[k] <= xi - dx;
					y_s[k] <= yi + dy;
					z_s[k] <= zi - ATAN_K;
				end
			end
		end
	end

	assign x_out = x_s[STEPS-1];
	assign y_out = y_s[STEPS-1];
	assign z_out = z_s[STEPS-1];

endmodule

// ===== design/hav_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module hav_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] n_in,
	output logic [30:0] root_out
);
	import hav_pkg::*;

	logic [60:0] rem_s  [31];
	logic [30:0] root_s [31];

	for (genvar k = 0; k < 31; k++) begin : g_bit
		localparam int B = 30 - k;
		logic [60:0] rem_in;
		logic [30:0] root_in;
		logic [62:0] delta;

		if (k == 0) begin : g_first
			assign rem_in  = n_in;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// (r + 2^B)^2 - r^2
		assign delta = ({32'd0, root_in} << (B + 1)) + (63'd1 << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if ({2'b00, rem_in} >= delta) begin
					rem_s[k]  <= rem_in - delta[60:0];
					root_s[k] <= root_in | (31'd1 << B);
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in;
				end
			end
		end
	end

	assign root_out = root_s[30];

endmodule

// ===== design/haversine_distance_core.sv =====
// Top level: pipelined haversine great-circle distance between two points.
//
// Input channel: first/second latitude and longitude in 1e-7 degree, with
// in_valid and in_stall; a point pair transfers when in_valid is high and
// in_stall is low. Output channel: distance_meters with out_valid and
// out_stall, same rule.
// One point pair enters per cycle unless the output holds a stalled result.
// The path runs through eleven arithmetic stages, two CORDIC pipelines of
// CORDIC_STEPS stages each, a 31-stage square root and two final stages.
// The whole pipeline advances together; when the output holds a result
// that the receiver stalls, every stage holds and in_stall rises, so no
// item is lost or repeated. Bubbles move forward while the output is empty.
// Reset clears all valid bits; payload registers are not reset.
module haversine_distance_core #(
	parameter int CORDIC_STEPS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [24:0] distance_meters
);
	import hav_pkg::*;

	localparam int LAT = 44 + 2 * CORDIC_STEPS;

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Stage 1: differences, latitude fold past the pole
	logic signed [33:0] dlat_s1, dlon_s1, lf1_s1, lf2_s1;
	logic               neg1_s1, neg2_s1;
	logic signed [33:0] lat1_x, lat2_x;

	assign lat1_x = 34'(first_latitude);
	assign lat2_x = 34'(second_latitude);

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= lat2_x - lat1_x;
			dlon_s1 <= 34'(second_longitude) - 34'(first_longitude);
			neg1_s1 <= (lat1_x > QUARTER_TURN) || (lat1_x < -QUARTER_TURN);
			neg2_s1 <= (lat2_x > QUARTER_TURN) || (lat2_x < -QUARTER_TURN);
			lf1_s1  <= (lat1_x > QUARTER_TURN) ? lat1_x - HALF_TURN :
			           (lat1_x < -QUARTER_TURN) ? lat1_x + HALF_TURN : lat1_x;
			lf2_s1  <= (lat2_x > QUARTER_TURN) ? lat2_x - HALF_TURN :
			           (lat2_x < -QUARTER_TURN) ? lat2_x + HALF_TURN : lat2_x;
		end
	end

	// Stage 2: wrap differences into half a turn, take magnitudes
	logic signed [33:0] dlat_w, dlon_w;
	logic        [30:0] mdlat_s2, mdlon_s2, ml1_s2, ml2_s2;
	logic               neg1_s2, neg2_s2;

	assign dlat_w = (dlat_s1 > HALF_TURN) ? dlat_s1 - FULL_TURN :
	                (dlat_s1 < -HALF_TURN) ? dlat_s1 + FULL_TURN : dlat_s1;
	assign dlon_w = (dlon_s1 > HALF_TURN) ? dlon_s1 - FULL_TURN :
	                (dlon_s1 < -HALF_TURN) ? dlon_s1 + FULL_TURN : dlon_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mdlat_s2 <= dlat_w[33] ? 31'(-dlat_w) : dlat_w[30:0];
			mdlon_s2 <= dlon_w[33] ? 31'(-dlon_w) : dlon_w[30:0];
			ml1_s2   <= lf1_s1[33] ? 31'(-lf1_s1) : lf1_s1[30:0];
			ml2_s2   <= lf2_s1[33] ? 31'(-lf2_s1) : lf2_s1[30:0];
			neg1_s2  <= neg1_s1;
			neg2_s2  <= neg2_s1;
		end
	end

	// Stage 3: degree-to-radian partial products
	logic [47:0] plo_s3 [4];
	logic [46:0] phi_s3 [4];
	logic        neg1_s3, neg2_s3;
	logic [30:0] mag_s2 [4];

	assign mag_s2[0] = mdlat_s2;
	assign mag_s2[1] = mdlon_s2;
	assign mag_s2[2] = ml1_s2;
	assign mag_s2[3] = ml2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				plo_s3[i] <= 48'(mag_s2[i]) * 48'(RAD_LO);
				phi_s3[i] <= 47'(mag_s2[i]) * 47'(RAD_HI);
			end
			neg1_s3 <= neg1_s2;
			neg2_s3 <= neg2_s2;
		end
	end

	// Stage 4: combine and round; differences are halved here
	logic [63:0]          full_s3 [4];
	logic signed [CW-1:0] z_s4 [4];
	logic                 neg1_s4, neg2_s4;

	for (genvar g = 0; g < 4; g++) begin : g_full
		assign full_s3[g] = {phi_s3[g], 17'd0} + 64'(plo_s3[g]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s4[0] <= CW'((full_s3[0] + (64'd1 << 32)) >> 33);
			z_s4[1] <= CW'((full_s3[1] + (64'd1 << 32)) >> 33);
			z_s4[2] <= CW'((full_s3[2] + (64'd1 << 31)) >> 32);
			z_s4[3] <= CW'((full_s3[3] + (64'd1 << 31)) >> 32);
			neg1_s4 <= neg1_s3;
			neg2_s4 <= neg2_s3;
		end
	end

	// Rotation CORDICs: half-angle sines and latitude cosines
	logic signed [CW-1:0] rx [4];
	logic signed [CW-1:0] ry [4];

	for (genvar g = 0; g < 4; g++) begin : g_rot
		hav_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot (
			.clk   (clk),
			.en    (en),
			.x_in  (GAIN_Q30),
			.y_in  ('0),
			.z_in  (z_s4[g]),
			.x_out (rx[g]),
			.y_out (ry[g]),
			.z_out ()
		);
	end

	logic [1:0] negd_q [CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			negd_q[0] <= {neg2_s4, neg1_s4};
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				negd_q[i] <= negd_q[i-1];
			end
		end
	end

	// Stage 5: apply the past-the-pole sign to the cosines
	logic signed [31:0] sl_s5, so_s5, c1_s5, c2_s5;
	logic [1:0]         negc;

	assign negc = negd_q[CORDIC_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sl_s5 <= $signed(ry[0][31:0]);
			so_s5 <= $signed(ry[1][31:0]);
			c1_s5 <= negc[0] ? $signed(32'(-rx[2])) : $signed(rx[2][31:0]);
			c2_s5 <= negc[1] ? $signed(32'(-rx[3])) : $signed(rx[3][31:0]);
		end
	end

	// Stage 6: squares and the cosine product
	logic signed [63:0] pl_s6, po_s6, pc_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s6 <= 64'(sl_s5) * 64'(sl_s5);
			po_s6 <= 64'(so_s5) * 64'(so_s5);
			pc_s6 <= 64'(c1_s5) * 64'(c2_s5);
		end
	end

	// Stage 7: round back to Q30
	localparam logic signed [63:0] RND29 = 64'sd536870912;
	logic signed [63:0] rl, ro, rc;
	logic signed [33:0] hsl_s7, hso_s7, cc_s7;

	assign rl = (pl_s6 + RND29) >>> 30;
	assign ro = (po_s6 + RND29) >>> 30;
	assign rc = (pc_s6 + RND29) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			hsl_s7 <= $signed(rl[33:0]);
			hso_s7 <= $signed(ro[33:0]);
			cc_s7  <= $signed(rc[33:0]);
		end
	end

	// Stage 8: cos1*cos2*sin^2(dLon/2)
	logic signed [63:0] pt_s8;
	logic signed [33:0] hsl_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s8  <= 64'($signed(cc_s7[31:0])) * 64'($signed(hso_s7[31:0]));
			hsl_s8 <= hsl_s7;
		end
	end

	// Stage 9: round
	logic signed [63:0] rt;
	logic signed [33:0] t_s9, hsl_s9;

	assign rt = (pt_s8 + RND29) >>> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s9   <= $signed(rt[33:0]);
			hsl_s9 <= hsl_s8;
		end
	end

	// Stage 10: a, clamped to [0, 1]
	logic signed [34:0] asum;
	logic        [30:0] a_s10;

	assign asum = 35'(hsl_s9) + 35'(t_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			if (asum < 0) begin
				a_s10 <= '0;
			end else if (asum > $signed({4'd0, ONE_Q30})) begin
				a_s10 <= ONE_Q30;
			end else begin
				a_s10 <= asum[30:0];
			end
		end
	end

	// Stage 11: root operands a and 1-a, scaled by 2^30
	logic [60:0] na_s11, nb_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			na_s11 <= {a_s10, 30'd0};
			nb_s11 <= {ONE_Q30 - a_s10, 30'd0};
		end
	end

	logic [30:0] ra, rb;

	hav_isqrt u_sqrt_a (.clk(clk), .en(en), .n_in(na_s11), .root_out(ra));
	hav_isqrt u_sqrt_b (.clk(clk), .en(en), .n_in(nb_s11), .root_out(rb));

	logic signed [CW-1:0] vz;

	hav_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_atan (
		.clk   (clk),
		.en    (en),
		.x_in  (CW'(rb)),
		.y_in  (CW'(ra)),
		.z_in  ('0),
		.x_out (),
		.y_out (),
		.z_out (vz)
	);

	// Stage 12: central angle c = 2*atan2, scaled by the radius
	logic [54:0] prod_s12;
	logic [31:0] cang;

	assign cang = vz[CW-1] ? 32'd0 : {vz[30:0], 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s12 <= 55'(cang) * 55'(EARTH_M);
		end
	end

	// Stage 13: round to meters
	logic [54:0] dist_r;
	logic [24:0] dist_q;

	assign dist_r = (prod_s12 + 55'(RND29)) >> 30;

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= dist_r[24:0];
		end
	end

	assign distance_meters = dist_q;

endmodule

// ===== design/hav_checker.sv =====
// Port-level checks for the haversine distance core, bound to the top level.
module hav_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [24:0] distance_meters
);

	// stall at the input only when the output holds a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without a stalled result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_meters))
		else $error("stalled result changed");

	// no distance exceeds 20100000 m, a margin above half the circumference
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_meters <= 25'd20100000)
		else $error("distance out of range");

endmodule

bind haversine_distance_core hav_checker u_hav_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.distance_meters (distance_meters)
);

// ===== dv/tb.sv =====
// Self-checking testbench for haversine_distance_core with a fixed-point distance predictor.
module tb;
	import hav_pkg::*;

	localparam int  STEPS      = 32;
	localparam int  LATENCY    = 44 + 2 * STEPS;
	localparam int  CYCLE_CAP  = 400000;
	localparam int  HOLD_LEN   = 400;
	localparam int  RAND_ITEMS = 1330;
	localparam longint unsigned DEG_TO_RAD =
		(64'hC90FDAA22168C234 + 64'd900000000) / 64'd1800000000;
	localparam longint Q30_ONE   = 64'sd1 << 30;
	localparam longint RADIUS_M  = 64'sd6371000;
	localparam longint DEG180    = 64'sd1800000000;
	localparam longint DEG360    = 64'sd3600000000;
	localparam longint DEG90     = 64'sd900000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [30:0] first_latitude;
	logic signed [31:0] first_longitude;
	logic signed [30:0] second_latitude;
	logic signed [31:0] second_longitude;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [24:0] distance_meters;

	haversine_distance_core #(.CORDIC_STEPS(STEPS)) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.first_latitude   (first_latitude),
		.first_longitude  (first_longitude),
		.second_latitude  (second_latitude),
		.second_longitude (second_longitude),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.distance_meters  (distance_meters)
	);

	logic [24:0] pending_distances[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          idle_pct;
	int          stall_pct;
	int          hold_requests;
	int          hold_served = 0;
	int          hold_left = 0;

	typedef struct {
		logic signed [30:0] lat1;
		logic signed [31:0] lon1;
		logic signed [30:0] lat2;
		logic signed [31:0] lon2;
		bit                 known;
		logic        [24:0] distance;
	} pair_row_t;

	pair_row_t directed[$];

	function automatic void add_row(pair_row_t r);
		directed.insert(directed.size(), r);
	endfunction

	// ---------------- predictor ----------------
	function automatic longint arctan_step(int i);
		longint head[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
		if (i < 11) return head[i];
		if (i <= 30) return 64'sd1 << (30 - i);
		return 0;
	endfunction

	function automatic longint angle_q30(longint unsigned mag, int shift);
		longint unsigned p;
		p = mag * DEG_TO_RAD + (64'd1 << (shift - 1));
		return longint'(p >> shift);
	endfunction

	function automatic void rotate(longint z, output longint c, output longint s);
		longint x, y, dx, dy;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_step(i);
			end else begin
				x += dx; y -= dy; z += arctan_step(i);
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arctan_step(i);
			end else begin
				x -= dx; y += dy; z -= arctan_step(i);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint abs_mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint half_sin_sq(longint d);
		longint c, s;
		if (d > DEG180) d -= DEG360;
		if (d < -DEG180) d += DEG360;
		rotate(angle_q30(abs_mag(d), 33), c, s);
		return qmul(s, s);
	endfunction

	function automatic longint latitude_cos(longint lat);
		longint c, s;
		bit flip;
		flip = 0;
		if (lat > DEG90) begin lat -= DEG180; flip = 1; end
		if (lat < -DEG90) begin lat += DEG180; flip = 1; end
		rotate(angle_q30(abs_mag(lat), 32), c, s);
		return flip ? -c : c;
	endfunction

	function automatic logic [24:0] great_circle_m(longint lat1, longint lon1,
		longint lat2, longint lon2);
		longint a, ra, rb, c;
		longint unsigned d;
		a = half_sin_sq(lat2 - lat1) +
			qmul(qmul(latitude_cos(lat1), latitude_cos(lat2)), half_sin_sq(lon2 - lon1));
		if (a < 0) a = 0;
		if (a > Q30_ONE) a = Q30_ONE;
		ra = longint'(int_root(longint'(a) << 30));
		rb = longint'(int_root(longint'(Q30_ONE - a) << 30));
		c = 2 * vector_angle(ra, rb);
		if (c < 0) c = 0;
		d = (longint'(c) * RADIUS_M + (64'sd1 << 29)) >> 30;
		return d[24:0];
	endfunction

	// ---------------- clock, reset, limit ----------------
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("haversine_distance_core verification failed");
			$finish;
		end
	end

	// ---------------- receiver ----------------
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall = 1;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// compare each transfer with the oldest pending distance
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_distances.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected distance %0d", distance_meters);
			end else begin
				logic [24:0] want;
				want = pending_distances.pop_front();
				if (distance_meters !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("distance mismatch: expected %0d got %0d", want,
							distance_meters);
				end
			end
		end
	end

	// ---------------- sender ----------------
	task automatic send_pair(pair_row_t r);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		first_latitude   = r.lat1;
		first_longitude  = r.lon1;
		second_latitude  = r.lat2;
		second_longitude = r.lon2;
		in_valid = 1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
			@(negedge clk);
		end
		pending_distances.insert(pending_distances.size(), r.known ? r.distance :
			great_circle_m(r.lat1, r.lon1, r.lat2, r.lon2));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 0;
		while (pending_distances.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	function automatic pair_row_t random_pair();
		pair_row_t r;
		r.known = 0;
		r.distance = '0;
		if ($urandom_range(9) == 0) begin
			// full field width, out-of-range latitudes and longitudes included
			r.lat1 = 31'($urandom);
			r.lon1 = $urandom;
			r.lat2 = 31'($urandom);
			r.lon2 = $urandom;
		end else if ($urandom_range(4) == 0) begin
			// nearby points
			r.lat1 = 31'(int'($urandom_range(32'd1800000000)) - 900000000);
			r.lon1 = int'($urandom_range(32'd3600000000)) - 1800000000;
			r.lat2 = 31'(r.lat1 + int'($urandom_range(20000)) - 10000);
			r.lon2 = r.lon1 + int'($urandom_range(20000)) - 10000;
		end else begin
			r.lat1 = 31'(int'($urandom_range(32'd1800000000)) - 900000000);
			r.lon1 = int'($urandom_range(32'd3600000000)) - 1800000000;
			r.lat2 = 31'(int'($urandom_range(32'd1800000000)) - 900000000);
			r.lon2 = int'($urandom_range(32'd3600000000)) - 1800000000;
		end
		return r;
	endfunction

	initial begin
		pair_row_t r;
		int phase_idle[4]  = '{0, 60, 0, 14};
		int phase_stall[4] = '{0, 0, 60, 14};

		in_valid = 0;
		first_latitude = '0;
		first_longitude = '0;
		second_latitude = '0;
		second_longitude = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_requests = 0;

		// identical points give zero distance
		add_row('{31'sd0, 32'sd0, 31'sd0, 32'sd0, 1, 25'd0});
		add_row('{31'sd900000000, 32'sd1800000000, 31'sd900000000,
			32'sd1800000000, 1, 25'd0});
		add_row('{-31'sd900000000, -32'sd1800000000, -31'sd900000000,
			-32'sd1800000000, 1, 25'd0});
		add_row('{31'sd123456789, -32'sd987654321, 31'sd123456789,
			-32'sd987654321, 1, 25'd0});
		// pole to pole, antipodes, half turn in longitude
		add_row('{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 0, '0});
		add_row('{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, 0, '0});
		add_row('{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000, 0, '0});
		add_row('{31'sd450000000, 32'sd0, -31'sd450000000, 32'sd1800000000, 0, '0});
		// longitude difference beyond half a turn
		add_row('{31'sd100000000, -32'sd1700000000, 31'sd100000000,
			32'sd1700000000, 0, '0});
		add_row('{31'sd0, 32'sd2147483647, 31'sd0, -32'sd2147483648, 0, '0});
		// latitudes beyond 90 degrees and field extremes
		add_row('{31'sd1073741823, 32'sd0, 31'sd0, 32'sd0, 0, '0});
		add_row('{-31'sd1073741824, 32'sd0, 31'sd1073741823, 32'sd0, 0, '0});
		add_row('{-31'sd1073741824, -32'sd2147483648, 31'sd1073741823,
			32'sd2147483647, 0, '0});
		add_row('{31'sd950000000, 32'sd300000000, -31'sd950000000,
			-32'sd300000000, 0, '0});
		// quarter turn and tiny steps
		add_row('{31'sd0, 32'sd0, 31'sd0, 32'sd900000000, 0, '0});
		add_row('{31'sd0, 32'sd0, 31'sd1, 32'sd0, 0, '0});
		add_row('{31'sd0, 32'sd0, 31'sd0, -32'sd1, 0, '0});
		add_row('{31'sd899999999, 32'sd0, 31'sd900000000, 32'sd1800000000, 0, '0});

		@(posedge arst_n);
		@(negedge clk);
		foreach (directed[k]) send_pair(directed[k]);
		drain_results();

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			for (int n = 0; n < RAND_ITEMS / 4; n++) begin
				// hold the receiver off long enough to fill the pipeline
				if (p == 0 && n == 60) hold_requests++;
				r = random_pair();
				send_pair(r);
			end
			drain_results();
		end

		stall_pct = 0;
		if (mismatches == 0 && pending_distances.size() == 0)
			$display("haversine_distance_core verification clean");
		else
			$display("haversine_distance_core verification failed");
		$finish;
	end

endmodule

// ===== haversine_distance_core.f =====
design/hav_pkg.sv
design/hav_cordic.sv
design/hav_isqrt.sv
design/haversine_distance_core.sv
design/hav_checker.sv
dv/tb.sv
